FILE: hw/rtl/heightmap_surface_frame_macros.svh
// ---------------------------------------------------------------------------
// heightmap_surface_frame_macros.svh
// Assertion helpers for the heightmap surface frame block.
// ---------------------------------------------------------------------------
`ifndef HEIGHTMAP_SURFACE_FRAME_MACROS_SVH
`define HEIGHTMAP_SURFACE_FRAME_MACROS_SVH

`ifndef SYNTHESIS
`define HSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define HSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HSF_ASSERT_IMP(lbl, ante, cons, msg)
`define HSF_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/hsf_pkg.sv
// ---------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants of the heightmap surface frame block.
// ---------------------------------------------------------------------------
package hsf_pkg;

  localparam int MAX_ROW_LENGTH = 1024;
  localparam int ADDR_W         = $clog2(MAX_ROW_LENGTH);
  localparam int CW             = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;
  localparam int RW             = 11;
  localparam int MAX_ROWS       = 1024;
  localparam int FIFO_DEPTH     = 2;

  typedef enum logic [2:0] {
    REG_ROW_LENGTH = 3'd0,
    REG_ROW_COUNT  = 3'd1,
    REG_SCALE_X    = 3'd2,
    REG_SCALE_Y    = 3'd3,
    REG_SCALE_Z    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [9:0] col;
    logic [9:0] row;
    logic       last;
    logic [7:0] h00;
    logic [7:0] h10;
    logic [7:0] h;
  } cell_task_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic signed [47:0] x;
    logic signed [47:0] y;
    logic signed [47:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } q14_vec_t;

endpackage

FILE: hw/rtl/hsf_front.sv
// ---------------------------------------------------------------------------
// hsf_front
// Sample intake: raster counters, line buffer, cell task issue.
// ---------------------------------------------------------------------------
module hsf_front import hsf_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      height_sample,
  input  logic            frame_start,
  input  logic [10:0]     row_length,
  input  logic [10:0]     row_count,
  input  fifo_status_t    fifo_st,
  output logic            push,
  output cell_task_t      task_out
);

  typedef enum logic [1:0] {F_IDLE, F_PLACE, F_PUSH} fstate_t;

  fstate_t         fstate;
  logic [CW-1:0]   col;
  logic [RW-1:0]   row;
  logic [7:0]      h_r;
  logic            fs_r;
  logic            emit_r;
  logic [9:0]      ccol_r;
  logic [9:0]      crow_r;
  logic            last_r;
  logic [7:0]      rd0;
  logic [7:0]      rd1;
  logic [7:0]      line_mem [MAX_ROW_LENGTH];

  logic [CW-1:0]   len;
  logic [RW-1:0]   rows;
  logic [CW-1:0]   c0, c1, c1p, col_next;
  logic [RW-1:0]   r0, r1, r2, row_next;
  logic            emit;
  logic            last;

  always_comb begin
    if (CW'(row_length) < CW'(2)) begin
      len = CW'(2);
    end else if (CW'(row_length) > CW'(MAX_ROW_LENGTH)) begin
      len = CW'(MAX_ROW_LENGTH);
    end else begin
      len = CW'(row_length);
    end
    if (row_count < RW'(2)) begin
      rows = RW'(2);
    end else if (row_count > RW'(MAX_ROWS)) begin
      rows = RW'(MAX_ROWS);
    end else begin
      rows = row_count;
    end
  end

  // wrap, place, then advance, as one sample step
  always_comb begin
    c0 = fs_r ? '0 : col;
    r0 = fs_r ? '0 : row;
    if (c0 >= len) begin
      c1 = '0;
      r1 = r0 + RW'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2   = (r1 >= rows) ? '0 : r1;
    c1p  = c1 + CW'(1);
    emit = (r2 != '0) && (c1p < len);
    last = (c1 + CW'(2) == len) && (r2 + RW'(1) == rows);
    if (c1p >= len) begin
      col_next = '0;
      row_next = (r2 + RW'(1) >= rows) ? '0 : r2 + RW'(1);
    end else begin
      col_next = c1p;
      row_next = r2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate <= F_IDLE;
      col    <= '0;
      row    <= '0;
      emit_r <= 1'b0;
    end else begin
      unique case (fstate)
        F_IDLE: begin
          if (in_valid) begin
            fstate <= F_PLACE;
          end
        end
        F_PLACE: begin
          col    <= col_next;
          row    <= row_next;
          emit_r <= emit;
          fstate <= F_PUSH;
        end
        F_PUSH: begin
          if (!emit_r || !fifo_st.full) begin
            fstate <= F_IDLE;
          end
        end
        default: fstate <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fstate == F_IDLE && in_valid) begin
      h_r  <= height_sample;
      fs_r <= frame_start;
    end
    if (fstate == F_PLACE) begin
      ccol_r <= c1[9:0];
      crow_r <= 10'(r2 - RW'(1));
      last_r <= last;
    end
  end

  // line buffer: two reads and one write, read data registered
  always_ff @(posedge clk) begin
    if (fstate == F_PLACE) begin
      rd0 <= line_mem[c1[ADDR_W-1:0]];
      rd1 <= line_mem[c1p[ADDR_W-1:0]];
      line_mem[c1[ADDR_W-1:0]] <= h_r;
    end
  end

  assign in_stall      = (fstate != F_IDLE);
  assign push          = (fstate == F_PUSH) && emit_r && !fifo_st.full;
  assign task_out.col  = ccol_r;
  assign task_out.row  = crow_r;
  assign task_out.last = last_r;
  assign task_out.h00  = rd0;
  assign task_out.h10  = rd1;
  assign task_out.h    = h_r;

endmodule

FILE: hw/rtl/hsf_fifo.sv
// ---------------------------------------------------------------------------
// hsf_fifo
// Short task queue between intake and the arithmetic back end.
// ---------------------------------------------------------------------------
module hsf_fifo import hsf_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cell_task_t    wdata,
  input  logic          pop,
  output cell_task_t    rdata,
  output fifo_status_t  status
);

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  cell_task_t       slots [FIFO_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(FIFO_DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PW'(FIFO_DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end

  assign rdata        = slots[rptr];
  assign status.full  = (count == (PW+1)'(FIFO_DEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: hw/rtl/hsf_norm.sv
// ---------------------------------------------------------------------------
// hsf_norm
// Shared vector normalizer: shift to range, sum of squares, bitwise
// square root, then restoring division per component into Q1.14.
// ---------------------------------------------------------------------------
module hsf_norm import hsf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  vec_t      vin,
  output logic      done,
  output q14_vec_t  vout
);

  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DLOAD, N_DSTEP} nstate_t;

  nstate_t             nstate;
  logic [47:0]         m [3];
  logic [2:0]          neg;
  logic [1:0]          idx;
  logic [63:0]         acc;
  logic [63:0]         rv;
  logic [63:0]         res;
  logic [63:0]         bitv;
  logic [31:0]         len;
  logic [47:0]         rem;
  logic [47:0]         dsh;
  logic [3:0]          dbit;
  logic [14:0]         q;
  logic signed [15:0]  o [3];

  logic [47:0]         mx;
  logic [59:0]         sq;
  logic [63:0]         trial;
  logic [63:0]         res_next;
  logic [14:0]         q_next;
  logic                take;

  always_comb begin
    mx = m[0];
    if (m[1] > mx) begin
      mx = m[1];
    end
    if (m[2] > mx) begin
      mx = m[2];
    end
    sq       = m[idx][29:0] * m[idx][29:0];
    trial    = res + bitv;
    res_next = (rv >= trial) ? (res >> 1) + bitv : res >> 1;
    take     = (rem >= dsh);
    q_next   = q | (take ? (15'(1) << dbit) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nstate <= N_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (nstate)
        N_IDLE: begin
          if (start) begin
            nstate <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mx == '0) begin
            done   <= 1'b1;
            nstate <= N_IDLE;
          end else if (mx[47:30] == '0 && mx[29]) begin
            nstate <= N_SQ;
          end
        end
        N_SQ: begin
          if (idx == 2'd2) begin
            nstate <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (bitv[0]) begin
            nstate <= N_DLOAD;
          end
        end
        N_DLOAD: nstate <= N_DSTEP;
        N_DSTEP: begin
          if (dbit == '0) begin
            if (idx == 2'd2) begin
              done   <= 1'b1;
              nstate <= N_IDLE;
            end else begin
              nstate <= N_DLOAD;
            end
          end
        end
        default: nstate <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (nstate)
      N_IDLE: begin
        if (start) begin
          m[0]   <= vin.x[47] ? 48'(-vin.x) : 48'(vin.x);
          m[1]   <= vin.y[47] ? 48'(-vin.y) : 48'(vin.y);
          m[2]   <= vin.z[47] ? 48'(-vin.z) : 48'(vin.z);
          neg[0] <= vin.x[47];
          neg[1] <= vin.y[47];
          neg[2] <= vin.z[47];
        end
      end
      N_SHIFT: begin
        idx <= '0;
        acc <= '0;
        if (mx == '0) begin
          o[0] <= '0;
          o[1] <= '0;
          o[2] <= '0;
        end else if (mx[47:30] != '0) begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= m[i] >> 1;
          end
        end else if (!mx[29]) begin
          for (int i = 0; i < 3; i++) begin
            m[i] <= m[i] << 1;
          end
        end
      end
      N_SQ: begin
        acc <= acc + 64'(sq);
        idx <= idx + 2'd1;
        if (idx == 2'd2) begin
          rv   <= acc + 64'(sq);
          res  <= '0;
          bitv <= 64'(1) << 62;
        end
      end
      N_ROOT: begin
        if (rv >= trial) begin
          rv <= rv - trial;
        end
        res  <= res_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len <= res_next[31:0];
          idx <= '0;
        end
      end
      N_DLOAD: begin
        // (m*2^15 + len) / (2*len): quotient fits 15 bits
        rem  <= {3'b0, m[idx][29:0], 15'b0} + 48'(len);
        dsh  <= 48'({len, 1'b0}) << 14;
        dbit <= 4'd14;
        q    <= '0;
      end
      N_DSTEP: begin
        if (take) begin
          rem <= rem - dsh;
        end
        dsh  <= dsh >> 1;
        q    <= q_next;
        dbit <= dbit - 4'd1;
        if (dbit == '0) begin
          o[idx] <= neg[idx] ? -16'(q_next) : 16'(q_next);
          idx    <= idx + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign vout.x = o[0];
  assign vout.y = o[1];
  assign vout.z = o[2];

endmodule

FILE: hw/rtl/hsf_back.sv
// ---------------------------------------------------------------------------
// hsf_back
// Cell arithmetic: edge vectors, cross product, four normalizations,
// Gram-Schmidt, handedness, and the output register.
// ---------------------------------------------------------------------------
module hsf_back import hsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cell_task_t         task_in,
  input  fifo_status_t       fifo_st,
  output logic               pop,
  input  logic [15:0]        scale_x,
  input  logic [15:0]        scale_y,
  input  logic [15:0]        scale_z,
  output logic               norm_start,
  output vec_t               norm_vin,
  input  logic               norm_done,
  input  q14_vec_t           norm_vout,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         cell_col,
  output logic [9:0]         cell_row,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic signed [15:0] bitangent_x,
  output logic signed [15:0] bitangent_y,
  output logic signed [15:0] bitangent_z,
  output logic               last_cell
);

  typedef enum logic [4:0] {
    B_IDLE, B_AY, B_BY, B_C0, B_C1, B_C2,
    B_NN, B_NN_W, B_NT, B_NT_W, B_NB, B_NB_W,
    B_DOT, B_GS, B_NG, B_NG_W, B_CR, B_HAND, B_OUT
  } bstate_t;

  bstate_t             bstate;
  cell_task_t          tk;
  logic [2:0]          k;
  logic signed [31:0]  ay;
  logic signed [31:0]  by;
  logic signed [47:0]  cr [3];
  logic signed [15:0]  n [3];
  logic signed [15:0]  t [3];
  logic signed [15:0]  b [3];
  logic signed [31:0]  d;
  logic signed [47:0]  g [3];
  logic signed [31:0]  c [3];
  logic signed [47:0]  hacc;

  logic signed [31:0]  ma;
  logic signed [31:0]  mb;
  logic signed [63:0]  prod;
  logic signed [8:0]   dh1;
  logic signed [8:0]   dh2;
  logic                flip;

  assign dh1  = $signed({1'b0, tk.h10}) - $signed({1'b0, tk.h00});
  assign dh2  = $signed({1'b0, tk.h}) - $signed({1'b0, tk.h00});
  assign prod = ma * mb;
  assign flip = hacc[47];

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (bstate)
      B_AY: begin
        ma = 32'(dh1);
        mb = 32'(scale_y);
      end
      B_BY: begin
        ma = 32'(dh2);
        mb = 32'(scale_y);
      end
      B_C0: begin
        ma = ay;
        mb = 32'(scale_z);
      end
      B_C1: begin
        ma = 32'(scale_x);
        mb = -32'(scale_z);
      end
      B_C2: begin
        ma = 32'(scale_x);
        mb = by;
      end
      B_DOT: begin
        ma = 32'(n[k[1:0]]);
        mb = 32'(t[k[1:0]]);
      end
      B_GS: begin
        ma = 32'(n[k[1:0]]);
        mb = d;
      end
      B_CR: begin
        unique case (k)
          3'd0: begin ma = 32'(n[1]); mb = 32'(t[2]); end
          3'd1: begin ma = 32'(n[2]); mb = 32'(t[1]); end
          3'd2: begin ma = 32'(n[2]); mb = 32'(t[0]); end
          3'd3: begin ma = 32'(n[0]); mb = 32'(t[2]); end
          3'd4: begin ma = 32'(n[0]); mb = 32'(t[1]); end
          3'd5: begin ma = 32'(n[1]); mb = 32'(t[0]); end
          default: begin ma = '0; mb = '0; end
        endcase
      end
      B_HAND: begin
        ma = c[k[1:0]];
        mb = 32'(b[k[1:0]]);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    norm_vin = '0;
    unique case (bstate)
      B_NN: begin
        norm_vin.x = cr[0];
        norm_vin.y = cr[1];
        norm_vin.z = cr[2];
      end
      B_NT: begin
        norm_vin.x = 48'(scale_x);
        norm_vin.y = 48'(ay);
      end
      B_NB: begin
        norm_vin.y = 48'(by);
        norm_vin.z = 48'(scale_z);
      end
      B_NG: begin
        norm_vin.x = g[0];
        norm_vin.y = g[1];
        norm_vin.z = g[2];
      end
      default: norm_vin = '0;
    endcase
  end

  assign norm_start = (bstate == B_NN) || (bstate == B_NT) ||
                      (bstate == B_NB) || (bstate == B_NG);
  assign pop        = (bstate == B_IDLE) && !fifo_st.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (bstate == B_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (bstate)
        B_IDLE:  if (!fifo_st.empty) bstate <= B_AY;
        B_AY:    bstate <= B_BY;
        B_BY:    bstate <= B_C0;
        B_C0:    bstate <= B_C1;
        B_C1:    bstate <= B_C2;
        B_C2:    bstate <= B_NN;
        B_NN:    bstate <= B_NN_W;
        B_NN_W:  if (norm_done) bstate <= B_NT;
        B_NT:    bstate <= B_NT_W;
        B_NT_W:  if (norm_done) bstate <= B_NB;
        B_NB:    bstate <= B_NB_W;
        B_NB_W: begin
          if (norm_done) begin
            bstate <= B_DOT;
            k      <= '0;
          end
        end
        B_DOT: begin
          k <= (k == 3'd2) ? '0 : k + 3'd1;
          if (k == 3'd2) bstate <= B_GS;
        end
        B_GS: begin
          k <= (k == 3'd2) ? '0 : k + 3'd1;
          if (k == 3'd2) bstate <= B_NG;
        end
        B_NG:    bstate <= B_NG_W;
        B_NG_W: begin
          if (norm_done) begin
            bstate <= B_CR;
            k      <= '0;
          end
        end
        B_CR: begin
          k <= (k == 3'd5) ? '0 : k + 3'd1;
          if (k == 3'd5) bstate <= B_HAND;
        end
        B_HAND: begin
          k <= (k == 3'd2) ? '0 : k + 3'd1;
          if (k == 3'd2) bstate <= B_OUT;
        end
        B_OUT: begin
          if (!out_valid || !out_stall) begin
            bstate <= B_IDLE;
          end
        end
        default: bstate <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (bstate)
      B_IDLE: begin
        if (!fifo_st.empty) begin
          tk <= task_in;
        end
        d    <= '0;
        hacc <= '0;
      end
      B_AY: ay    <= prod[31:0];
      B_BY: by    <= prod[31:0];
      B_C0: cr[0] <= prod[47:0];
      B_C1: cr[1] <= prod[47:0];
      B_C2: cr[2] <= prod[47:0];
      B_NN_W: begin
        if (norm_done) begin
          n[0] <= norm_vout.x;
          n[1] <= norm_vout.y;
          n[2] <= norm_vout.z;
        end
      end
      B_NT_W: begin
        if (norm_done) begin
          t[0] <= norm_vout.x;
          t[1] <= norm_vout.y;
          t[2] <= norm_vout.z;
        end
      end
      B_NB_W: begin
        if (norm_done) begin
          b[0] <= norm_vout.x;
          b[1] <= norm_vout.y;
          b[2] <= norm_vout.z;
        end
      end
      B_DOT: d <= d + prod[31:0];
      B_GS:  g[k[1:0]] <= (48'(t[k[1:0]]) <<< 28) - prod[47:0];
      B_NG_W: begin
        if (norm_done) begin
          t[0] <= norm_vout.x;
          t[1] <= norm_vout.y;
          t[2] <= norm_vout.z;
        end
      end
      B_CR: begin
        // even step loads a product, odd step subtracts the second one
        if (!k[0]) begin
          c[k[2:1]] <= prod[31:0];
        end else begin
          c[k[2:1]] <= c[k[2:1]] - prod[31:0];
        end
      end
      B_HAND: hacc <= hacc + prod[47:0];
      B_OUT: begin
        if (!out_valid || !out_stall) begin
          cell_col    <= tk.col;
          cell_row    <= tk.row;
          last_cell   <= tk.last;
          normal_x    <= n[0];
          normal_y    <= n[1];
          normal_z    <= n[2];
          tangent_x   <= flip ? -t[0] : t[0];
          tangent_y   <= flip ? -t[1] : t[1];
          tangent_z   <= flip ? -t[2] : t[2];
          bitangent_x <= b[0];
          bitangent_y <= b[1];
          bitangent_z <= b[2];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/heightmap_surface_frame.sv
// ---------------------------------------------------------------------------
// heightmap_surface_frame
// Surface normal, tangent and bitangent per grid cell of a heightmap.
// ---------------------------------------------------------------------------
// Input channel: one 8-bit height per transfer in raster order (in_valid,
// in_stall); frame_start puts the sample at column 0, row 0. The intake
// takes a sample only once the last one is placed and its task pushed.
// Output channel: one cell result per transfer (out_valid, out_stall) for
// each sample past the first row and not in the last column; the result
// describes the cell above-right of that sample, in Q1.14.
// The back end's time per cell is set mostly by four passes through the
// single shared normalizer (shift to range, square root, a division per
// component), less when a scale is zero and a vector vanishes; the back
// end's one multiplier does the rest.
// A two-entry queue sits between intake and back end; a stalled output
// holds its result and the back end waits, and the queue then fills and
// stalls the input. Reset clears counters, queue and output valid; the
// line buffer is not cleared. Registers via the APB port, at 4*index.
// ---------------------------------------------------------------------------
`include "heightmap_surface_frame_macros.svh"

module heightmap_surface_frame import hsf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         height_sample,
  input  logic               frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         cell_col,
  output logic [9:0]         cell_row,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic signed [15:0] tangent_x,
  output logic signed [15:0] tangent_y,
  output logic signed [15:0] tangent_z,
  output logic signed [15:0] bitangent_x,
  output logic signed [15:0] bitangent_y,
  output logic signed [15:0] bitangent_z,
  output logic               last_cell
);

  logic [10:0]   row_length;
  logic [10:0]   row_count;
  logic [15:0]   scale_x;
  logic [15:0]   scale_y;
  logic [15:0]   scale_z;
  reg_idx_t      reg_sel;
  logic          cfg_wr;

  cell_task_t    push_task;
  cell_task_t    pop_task;
  fifo_status_t  fifo_st;
  logic          fifo_push;
  logic          fifo_pop;
  logic          norm_start;
  logic          norm_done;
  vec_t          norm_vin;
  q14_vec_t      norm_vout;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= 11'd256;
      row_count  <= 11'd256;
      scale_x    <= 16'd7680;
      scale_y    <= 16'd51;
      scale_z    <= 16'd7680;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_ROW_LENGTH: row_length <= pwdata[10:0];
        REG_ROW_COUNT:  row_count  <= pwdata[10:0];
        REG_SCALE_X:    scale_x    <= pwdata[15:0];
        REG_SCALE_Y:    scale_y    <= pwdata[15:0];
        REG_SCALE_Z:    scale_z    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_ROW_LENGTH: prdata = 32'(row_length);
      REG_ROW_COUNT:  prdata = 32'(row_count);
      REG_SCALE_X:    prdata = 32'(scale_x);
      REG_SCALE_Y:    prdata = 32'(scale_y);
      REG_SCALE_Z:    prdata = 32'(scale_z);
      default:        prdata = '0;
    endcase
  end

  hsf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .height_sample (height_sample),
    .frame_start   (frame_start),
    .row_length    (row_length),
    .row_count     (row_count),
    .fifo_st       (fifo_st),
    .push          (fifo_push),
    .task_out      (push_task)
  );

  hsf_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (fifo_push),
    .wdata  (push_task),
    .pop    (fifo_pop),
    .rdata  (pop_task),
    .status (fifo_st)
  );

  hsf_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vin   (norm_vin),
    .done  (norm_done),
    .vout  (norm_vout)
  );

  hsf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .task_in     (pop_task),
    .fifo_st     (fifo_st),
    .pop         (fifo_pop),
    .scale_x     (scale_x),
    .scale_y     (scale_y),
    .scale_z     (scale_z),
    .norm_start  (norm_start),
    .norm_vin    (norm_vin),
    .norm_done   (norm_done),
    .norm_vout   (norm_vout),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .tangent_x   (tangent_x),
    .tangent_y   (tangent_y),
    .tangent_z   (tangent_z),
    .bitangent_x (bitangent_x),
    .bitangent_y (bitangent_y),
    .bitangent_z (bitangent_z),
    .last_cell   (last_cell)
  );

  `HSF_ASSERT_IMP(a_no_push_full, fifo_push, !fifo_st.full, "task pushed into full queue")
  `HSF_ASSERT_IMP(a_no_pop_empty, fifo_pop, !fifo_st.empty, "task popped from empty queue")
  `HSF_ASSERT_NXT(a_busy_after_take, in_valid && !in_stall, in_stall, "intake not busy after transfer")
  `HSF_ASSERT_NXT(a_norm_start_done, norm_start, !norm_done, "normalizer done right after start")

endmodule
